// ===== rtl/core/rv32i_instruction_decoder_defines.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef RV32I_INSTRUCTION_DECODER_DEFINES_SVH
`define RV32I_INSTRUCTION_DECODER_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define RVDEC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define RVDEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define RVDEC_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/rvdec_pkg.sv =====
// Types, encodings and helper functions of the RV32I decoder.
package rvdec_pkg;

   // major opcodes
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6f;

   localparam logic [2:0] F3_ADD = 3'd0;
   localparam logic [2:0] F3_SR  = 3'd5;
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   // ADDI x, x, 255 marks end of program
   localparam logic [11:0] END_IMM      = 12'd255;
   localparam logic [31:0] END_SENTINEL = 32'hfffe40ae;

   // instruction classes
   localparam logic [2:0] CLS_NONE   = 3'd0;
   localparam logic [2:0] CLS_CALC   = 3'd1;
   localparam logic [2:0] CLS_LOAD   = 3'd2;
   localparam logic [2:0] CLS_STORE  = 3'd3;
   localparam logic [2:0] CLS_BRANCH = 3'd4;
   localparam logic [2:0] CLS_END    = 3'd5;

   // sub-operations
   localparam logic [3:0] SUB_ADD  = 4'd0;
   localparam logic [3:0] SUB_SLL  = 4'd2;
   localparam logic [3:0] SUB_LT   = 4'd3;
   localparam logic [3:0] SUB_LTU  = 4'd4;
   localparam logic [3:0] SUB_XOR  = 4'd5;
   localparam logic [3:0] SUB_SRL  = 4'd6;
   localparam logic [3:0] SUB_OR   = 4'd8;
   localparam logic [3:0] SUB_AND  = 4'd9;
   localparam logic [3:0] SUB_IMM  = 4'd10;
   localparam logic [3:0] SUB_JAL  = 4'd6;
   localparam logic [3:0] SUB_JALR = 4'd7;
   localparam logic [3:0] SUB_ALT_STEP    = 4'd1;
   localparam logic [3:0] SUB_BRANCH_BIAS = 4'd2;

   // operand flags
   localparam logic [3:0] FLAG_RD   = 4'b0001;
   localparam logic [3:0] FLAG_IMM  = 4'b0010;
   localparam logic [3:0] FLAG_PC   = 4'b0100;
   localparam logic [3:0] FLAG_SEXT = 4'b1000;

   typedef struct packed {
      logic        illegal_insn;
      logic        predicted_taken_out;
      logic [31:0] predicted_target_out;
      logic [31:0] immediate_value;
      logic [3:0]  operand_flags;
      logic [3:0]  sub_op;
      logic [2:0]  insn_class;
      logic [4:0]  dest_reg;
      logic [4:0]  source_reg_two;
      logic [4:0]  source_reg_one;
      logic [31:0] pc_out;
   } uop_type;

   localparam int REQ_BITS = 104;
   localparam int RSP_BITS = 128;

   // funct3 to ALU sub-op, funct7 alternate adds one
   function automatic logic [3:0] alu_sub(input logic [2:0] f3);
      logic [3:0] s;
      case (f3)
         3'd0:    s = SUB_ADD;
         3'd1:    s = SUB_SLL;
         3'd2:    s = SUB_LT;
         3'd3:    s = SUB_LTU;
         3'd4:    s = SUB_XOR;
         3'd5:    s = SUB_SRL;
         3'd6:    s = SUB_OR;
         3'd7:    s = SUB_AND;
         default: s = SUB_ADD;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/rvdec_decode.sv =====
// Combinational RV32I field decode of one registered request.
module rvdec_decode (
   input  logic [31:0]       instruction_word,
   input  logic [31:0]       fetch_pc,
   input  logic [31:0]       predicted_target_in,
   input  logic              predicted_taken_in,
   output rvdec_pkg::uop_type uop
);

   logic [6:0]  opcode;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
   logic [2:0]  cls;
   logic [3:0]  sub;
   logic [3:0]  flg;
   logic [31:0] imm;
   logic [31:0] tgt;
   logic        bad;

   assign opcode = instruction_word[6:0];
   assign f3     = instruction_word[14:12];
   assign f7     = instruction_word[31:25];

   assign imm_i = {{20{instruction_word[31]}}, instruction_word[31:20]};
   assign imm_s = {{20{instruction_word[31]}}, instruction_word[31:25],
                   instruction_word[11:7]};
   assign imm_b = {{19{instruction_word[31]}}, instruction_word[31], instruction_word[7],
                   instruction_word[30:25], instruction_word[11:8], 1'b0};
   assign imm_u = {instruction_word[31:12], 12'd0};
   assign imm_j = {{11{instruction_word[31]}}, instruction_word[31],
                   instruction_word[19:12], instruction_word[20],
                   instruction_word[30:21], 1'b0};

   always_comb begin
      cls = rvdec_pkg::CLS_NONE;
      sub = rvdec_pkg::SUB_ADD;
      flg = 4'd0;
      imm = 32'd0;
      tgt = predicted_target_in;
      bad = 1'b0;
      case (opcode)
         rvdec_pkg::OPC_OP: begin
            cls = rvdec_pkg::CLS_CALC;
            flg = rvdec_pkg::FLAG_RD;
            sub = rvdec_pkg::alu_sub(f3);
            if (f3 == rvdec_pkg::F3_ADD || f3 == rvdec_pkg::F3_SR) begin
               if (f7 == rvdec_pkg::F7_ALT) sub = sub + rvdec_pkg::SUB_ALT_STEP;
               else if (f7 != rvdec_pkg::F7_BASE) bad = 1'b1;
            end
         end
         rvdec_pkg::OPC_OP_IMM: begin
            cls = rvdec_pkg::CLS_CALC;
            flg = rvdec_pkg::FLAG_RD | rvdec_pkg::FLAG_IMM;
            sub = rvdec_pkg::alu_sub(f3);
            imm = imm_i;
            if (f3 == rvdec_pkg::F3_ADD && instruction_word[31:20] == rvdec_pkg::END_IMM) begin
               cls = rvdec_pkg::CLS_END;
               tgt = rvdec_pkg::END_SENTINEL;
            end else if (f3 == rvdec_pkg::F3_SR) begin
               imm = {27'd0, imm_i[4:0]};  // shift amount only
               if (f7 == rvdec_pkg::F7_ALT) sub = sub + rvdec_pkg::SUB_ALT_STEP;
               else if (f7 != rvdec_pkg::F7_BASE) bad = 1'b1;
            end
         end
         rvdec_pkg::OPC_LOAD: begin
            cls = rvdec_pkg::CLS_LOAD;
            flg = rvdec_pkg::FLAG_RD;
            imm = imm_i;
            if (f3 inside {3'd0, 3'd1, 3'd2}) begin
               sub = {1'b0, f3};
               flg = rvdec_pkg::FLAG_RD | rvdec_pkg::FLAG_SEXT;
            end else if (f3 inside {3'd4, 3'd5}) begin
               sub = {3'd0, f3[0]};  // LBU / LHU
            end else begin
               bad = 1'b1;
            end
         end
         rvdec_pkg::OPC_JALR: begin
            cls = rvdec_pkg::CLS_BRANCH;
            sub = rvdec_pkg::SUB_JALR;
            flg = rvdec_pkg::FLAG_RD;
            imm = imm_i;
         end
         rvdec_pkg::OPC_STORE: begin
            cls = rvdec_pkg::CLS_STORE;
            imm = imm_s;
            if (f3 inside {3'd0, 3'd1, 3'd2}) sub = {1'b0, f3};
            else bad = 1'b1;
         end
         rvdec_pkg::OPC_BRANCH: begin
            cls = rvdec_pkg::CLS_BRANCH;
            imm = imm_b;
            if (f3 inside {3'd0, 3'd1}) sub = {1'b0, f3};
            else if (f3 inside {3'd4, 3'd5, 3'd6, 3'd7})
               sub = {1'b0, f3} - rvdec_pkg::SUB_BRANCH_BIAS;
            else bad = 1'b1;
         end
         rvdec_pkg::OPC_LUI: begin
            cls = rvdec_pkg::CLS_CALC;
            sub = rvdec_pkg::SUB_IMM;
            flg = rvdec_pkg::FLAG_RD | rvdec_pkg::FLAG_IMM;
            imm = imm_u;
         end
         rvdec_pkg::OPC_AUIPC: begin
            cls = rvdec_pkg::CLS_CALC;
            sub = rvdec_pkg::SUB_ADD;
            flg = rvdec_pkg::FLAG_RD | rvdec_pkg::FLAG_IMM | rvdec_pkg::FLAG_PC;
            imm = imm_u;
         end
         rvdec_pkg::OPC_JAL: begin
            cls = rvdec_pkg::CLS_BRANCH;
            sub = rvdec_pkg::SUB_JAL;
            flg = rvdec_pkg::FLAG_RD | rvdec_pkg::FLAG_IMM;
            imm = imm_j;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (bad) begin
         uop              = '0;
         uop.illegal_insn = 1'b1;
      end else begin
         uop.pc_out               = fetch_pc;
         uop.source_reg_one       = instruction_word[19:15];
         uop.source_reg_two       = instruction_word[24:20];
         uop.dest_reg             = instruction_word[11:7];
         uop.insn_class           = cls;
         uop.sub_op               = sub;
         uop.operand_flags        = flg;
         uop.immediate_value      = imm;
         uop.predicted_target_out = tgt;
         uop.predicted_taken_out  = predicted_taken_in;
         uop.illegal_insn         = 1'b0;
      end
   end

endmodule

// ===== rtl/core/rv32i_instruction_decoder.sv =====
// RV32I instruction decoder: request register, field decode, result register.
// An accepted request is decoded from stage 1 and offered once loaded into stage 2.
// One request per cycle unless rsp stalls; decode is a single pass between registers.
// Backpressure on rsp stalls stage 2 and a full stage 1; req_tready drops only then.
// Reset (synchronous, active high) empties both stages; payload regs are not reset.
`include "rv32i_instruction_decoder_defines.svh"

module rv32i_instruction_decoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] instruction_word, [63:32] fetch_pc, [95:64] predicted_target_in,
   // [96] predicted_taken_in, [103:97] zero
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] pc_out, [36:32] source_reg_one, [41:37] source_reg_two,
   // [46:42] dest_reg, [49:47] insn_class, [53:50] sub_op, [57:54] operand_flags,
   // [89:58] immediate_value, [121:90] predicted_target_out,
   // [122] predicted_taken_out, [123] illegal_insn, [127:124] zero
   output logic [127:0] rsp_tdata
);

   // stage 1: captured request
   logic        req_valid_ff, req_valid_in;
   logic [31:0] word_ff, pc_ff, tgt_ff;
   logic        taken_ff;

   // stage 2: decoded result
   logic               rsp_valid_ff, rsp_valid_in;
   rvdec_pkg::uop_type uop_ff;
   rvdec_pkg::uop_type uop_dec;

   logic rsp_adv;   // result register may load
   logic req_adv;   // request register may load

   assign rsp_adv    = !rsp_valid_ff || rsp_tready;
   assign req_adv    = !req_valid_ff || rsp_adv;
   assign req_tready = req_adv;

   assign req_valid_in = req_adv ? req_tvalid : req_valid_ff;
   assign rsp_valid_in = rsp_adv ? req_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_adv && req_tvalid) begin
         word_ff  <= req_tdata[31:0];
         pc_ff    <= req_tdata[63:32];
         tgt_ff   <= req_tdata[95:64];
         taken_ff <= req_tdata[96];
      end
   end

   rvdec_decode u_decode (
      .instruction_word    (word_ff),
      .fetch_pc            (pc_ff),
      .predicted_target_in (tgt_ff),
      .predicted_taken_in  (taken_ff),
      .uop                 (uop_dec)
   );

   always_ff @(posedge clock) begin
      if (rsp_adv && req_valid_ff) uop_ff <= uop_dec;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, uop_ff};

   // a staged request moves into the result register when it is free
   `RVDEC_ASSERT_NEXT(a_stage_moves, clock, reset,
      req_valid_ff && rsp_adv, rsp_valid_ff, "staged request lost")
   // an accepted request always lands in stage 1
   `RVDEC_ASSERT_NEXT(a_req_lands, clock, reset,
      req_tvalid && req_tready, req_valid_ff, "accepted request dropped")
   // END marker carries the sentinel target
   `RVDEC_ASSERT_SAME(a_end_sentinel, clock, reset,
      rsp_tvalid && uop_ff.insn_class == rvdec_pkg::CLS_END,
      uop_ff.predicted_target_out == rvdec_pkg::END_SENTINEL, "END without sentinel target")
   // reset empties the pipeline
   `RVDEC_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset,
      !rsp_valid_ff && !req_valid_ff, "valid after reset")

endmodule
